/* hdl/audio_looper_overdub_assert.svh */
// assertion macros used by the looper rtl
`ifndef AUDIO_LOOPER_OVERDUB_ASSERT_SVH
`define AUDIO_LOOPER_OVERDUB_ASSERT_SVH

// condition implies a consequence in the same cycle
`define ALO_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("looper check failed in the same cycle");

// condition implies a consequence in the next cycle
`define ALO_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("looper check failed one cycle later");

`endif

/* hdl/alo_pkg.sv */
package alo_pkg;

   // sample format
   localparam int SAMPLE_BITS = 16;
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // gains, Q1.15
   localparam int Q_ONE        = 32768;
   localparam int FEEDBACK_MAX = 29491;
   localparam int MIX_RESET    = 16384;
   localparam int FB_RESET     = 16384;
   localparam int LENGTH_RESET = 176400;

   // accumulator for products and their sum
   localparam int ACC_W = 36;
   localparam logic signed [ACC_W-1:0] ACC_HALF = 36'sd16384;
   localparam logic signed [ACC_W-1:0] SAT_MAX  = 36'sd32767;
   localparam logic signed [ACC_W-1:0] SAT_MIN  = -36'sd32768;

   // configuration register indexes
   localparam int CSR_DATA_W = 19;
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_MIX      = 2'd0;
   localparam csr_index_type CSR_FEEDBACK = 2'd1;
   localparam csr_index_type CSR_LENGTH   = 2'd2;

   typedef enum logic [2:0] {
      OP_SAMPLE     = 3'd0,
      OP_REC_START  = 3'd1,
      OP_REC_STOP   = 3'd2,
      OP_PLAY_START = 3'd3,
      OP_PLAY_STOP  = 3'd4,
      OP_CLEAR      = 3'd5
   } op_type;

   typedef struct packed {
      op_type     op;
      sample_type sample_in;
   } req_type;

   typedef struct packed {
      sample_type sample_out;
      logic       is_recording;
      logic       is_playing;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_INIT_CLR,
      ST_IDLE,
      ST_CLEAR,
      ST_MIX,
      ST_RND,
      ST_FBM,
      ST_WR,
      ST_DONE
   } alo_state_type;

   // add one half, floor by 2^15, saturate to the sample range
   function automatic sample_type round_sat(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      logic signed [ACC_W-1:0] q;
      r = v + ACC_HALF;
      q = r >>> 15;
      if (q > SAT_MAX) begin
         q = SAT_MAX;
      end else if (q < SAT_MIN) begin
         q = SAT_MIN;
      end
      return sample_type'(q[SAMPLE_BITS-1:0]);
   endfunction

endpackage

/* hdl/audio_looper_overdub.sv */
// control items give their result from the done state, as do samples while not
//   playing; a sample while playing passes through store read and mix multiply,
//   rounding, feedback multiply, then write back into the loop memory
// a new item is taken only after the last one has handed off its result; clear
//   walks the whole store, one memory entry zeroed per cycle
// reset: synchronous; flags, positions and gains return to defaults, then a zeroing
//   pass over all LOOP_DEPTH entries (262144 by default) runs with input stalled
`include "audio_looper_overdub_assert.svh"

module audio_looper_overdub
   import alo_pkg::*;
#(
   parameter int LOOP_DEPTH = 262144
) (
   input  logic          clock,
   input  logic          reset,
   // input items
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   // results
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   // configuration writes
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW  = $clog2(LOOP_DEPTH);
   localparam int AW1 = AW + 1;
   localparam int LW  = $clog2(LOOP_DEPTH + 1);
   localparam int CW  = (LW > CSR_DATA_W) ? LW : CSR_DATA_W;
   localparam logic [LW-1:0] LEN_RESET =
      (LENGTH_RESET > LOOP_DEPTH) ? LW'(LOOP_DEPTH) : LW'(LENGTH_RESET);

   // position step with wrap at the loop length
   function automatic logic [AW-1:0] adv(input logic [AW-1:0] pos,
                                          input logic [LW-1:0] len);
      logic [AW1-1:0] nxt;
      nxt = {1'b0, pos} + AW1'(1);
      if (nxt >= AW1'(len)) begin
         return '0;
      end
      return nxt[AW-1:0];
   endfunction

   alo_state_type state_ff, state_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] rp_ff, rp_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          rec_ff, rec_in;
   logic          play_ff, play_in;
   logic          fwd_ff, fwd_in;
   logic [15:0]   mix_ff, mix_in;
   logic [14:0]   fb_ff, fb_in;
   logic [LW-1:0] len_ff, len_in;
   sample_type    x_ff, x_in;
   sample_type    res_ff, res_in;
   logic signed [ACC_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] fbp_ff, fbp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [SAMPLE_BITS-1:0] ram_wdata;
   logic [SAMPLE_BITS-1:0] ram_rdata;

   logic          accept;
   logic          out_free;
   sample_type    stored;
   logic [16:0]   omix;
   logic signed [33:0] p_in;
   logic signed [33:0] p_loop;
   logic signed [31:0] p_fb;
   sample_type    fb_sample;
   logic [CW-1:0] len_req;

   alo_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(LOOP_DEPTH)
   ) u_loop_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(rp_ff),
      .rdata(ram_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // datapath terms
   assign stored    = fwd_ff ? x_ff : sample_type'(ram_rdata);
   assign omix      = 17'(Q_ONE) - {1'b0, mix_ff};
   assign p_in      = x_ff * signed'({1'b0, omix});
   assign p_loop    = stored * signed'({2'b00, mix_ff});
   assign p_fb      = res_ff * signed'({1'b0, fb_ff});
   assign fb_sample = round_sat(fbp_ff);
   assign len_req   = CW'(csr_data);

   // next state, datapath and memory control
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      clr_in       = clr_ff;
      rec_in       = rec_ff;
      play_in      = play_ff;
      fwd_in       = fwd_ff;
      mix_in       = mix_ff;
      fb_in        = fb_ff;
      len_in       = len_ff;
      x_in         = x_ff;
      res_in       = res_ff;
      prod_in      = prod_ff;
      fbp_in       = fbp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = wp_ff;
      ram_wdata    = '0;

      unique case (state_ff)
         ST_INIT_CLR, ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(LOOP_DEPTH - 1)) begin
               clr_in   = '0;
               state_in = (state_ff == ST_INIT_CLR) ? ST_IDLE : ST_DONE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               x_in   = req_data.sample_in;
               res_in = '0;
               unique case (req_data.op)
                  OP_SAMPLE: begin
                     // record write goes in now, the play read runs alongside
                     fwd_in = rec_ff && (wp_ff == rp_ff);
                     if (rec_ff) begin
                        ram_we    = 1'b1;
                        ram_wdata = req_data.sample_in;
                        wp_in     = adv(wp_ff, len_ff);
                     end
                     res_in   = req_data.sample_in;
                     state_in = play_ff ? ST_MIX : ST_DONE;
                  end
                  OP_REC_START: begin
                     rec_in   = 1'b1;
                     play_in  = 1'b0;
                     wp_in    = '0;
                     state_in = ST_DONE;
                  end
                  OP_REC_STOP: begin
                     rec_in   = 1'b0;
                     play_in  = 1'b1;
                     rp_in    = '0;
                     state_in = ST_DONE;
                  end
                  OP_PLAY_START: begin
                     play_in  = 1'b1;
                     state_in = ST_DONE;
                  end
                  OP_PLAY_STOP: begin
                     play_in  = 1'b0;
                     state_in = ST_DONE;
                  end
                  OP_CLEAR: begin
                     rec_in   = 1'b0;
                     play_in  = 1'b0;
                     wp_in    = '0;
                     rp_in    = '0;
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MIX: begin
            prod_in  = ACC_W'(p_in) + ACC_W'(p_loop);
            state_in = ST_RND;
         end
         ST_RND: begin
            res_in   = round_sat(prod_ff);
            state_in = ST_FBM;
         end
         ST_FBM: begin
            fbp_in   = ACC_W'(p_fb);
            state_in = ST_WR;
         end
         ST_WR: begin
            // feedback write and result hand-off happen together
            if (out_free) begin
               ram_we                   = 1'b1;
               ram_wdata                = fb_sample;
               wp_in                    = adv(wp_ff, len_ff);
               rp_in                    = adv(rp_ff, len_ff);
               rsp_valid_in             = 1'b1;
               rsp_data_in.sample_out   = res_ff;
               rsp_data_in.is_recording = rec_ff;
               rsp_data_in.is_playing   = play_ff;
               state_in                 = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.sample_out   = res_ff;
               rsp_data_in.is_recording = rec_ff;
               rsp_data_in.is_playing   = play_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // configuration transaction, gains and length kept in clamped form
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MIX: begin
               mix_in = (csr_data[15:0] > 16'(Q_ONE)) ? 16'(Q_ONE) : csr_data[15:0];
            end
            CSR_FEEDBACK: begin
               fb_in = (csr_data[14:0] > 15'(FEEDBACK_MAX)) ? 15'(FEEDBACK_MAX)
                                                             : csr_data[14:0];
            end
            CSR_LENGTH: begin
               priority if (len_req == '0) begin
                  len_in = LW'(1);
               end else if (len_req > CW'(LOOP_DEPTH)) begin
                  len_in = LW'(LOOP_DEPTH);
               end else begin
                  len_in = LW'(len_req);
               end
               wp_in = '0;
               rp_in = '0;
            end
            default: begin
               len_in = len_ff;
            end
         endcase
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT_CLR;
         wp_ff        <= '0;
         rp_ff        <= '0;
         clr_ff       <= '0;
         rec_ff       <= 1'b0;
         play_ff      <= 1'b0;
         fwd_ff       <= 1'b0;
         mix_ff       <= 16'(MIX_RESET);
         fb_ff        <= 15'(FB_RESET);
         len_ff       <= LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         clr_ff       <= clr_in;
         rec_ff       <= rec_in;
         play_ff      <= play_in;
         fwd_ff       <= fwd_in;
         mix_ff       <= mix_in;
         fb_ff        <= fb_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff        <= x_in;
      res_ff      <= res_in;
      prod_ff     <= prod_in;
      fbp_ff      <= fbp_in;
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   `ALO_ASSERT_SAME(a_pos_in_loop, clock, reset, 1'b1,
      (AW1'(wp_ff) < AW1'(len_ff)) && (AW1'(rp_ff) < AW1'(len_ff)))
   `ALO_ASSERT_SAME(a_no_result_in_init, clock, reset, state_ff == ST_INIT_CLR, !rsp_valid_ff)
   `ALO_ASSERT_NEXT(a_mix_only_playing, clock, reset, state_ff == ST_IDLE && accept &&
      req_data.op == OP_SAMPLE && play_ff, state_ff == ST_MIX)

endmodule

/* hdl/alo_ram.sv */
module alo_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port, old data on collision
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* tb/tb_audio_looper_overdub.sv */
`timescale 1ns / 100ps

import alo_pkg::*;

// predicts the looper results and checks them in arrival order
class loop_predictor;
   sample_type    loop_mem [int];
   int unsigned   wr_pos;
   int unsigned   rd_pos;
   bit            recording;
   bit            playing;
   int unsigned   mix_reg;
   int unsigned   fb_reg;
   int unsigned   length_reg;
   rsp_type       expected_q [$];
   int            errors;

   function new();
      wr_pos     = 0;
      rd_pos     = 0;
      recording  = 1'b0;
      playing    = 1'b0;
      mix_reg    = MIX_RESET;
      fb_reg     = FB_RESET;
      length_reg = LENGTH_RESET;
      errors     = 0;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // circular advance over the effective loop length
   function int unsigned next_pos(int unsigned p);
      int unsigned span;
      span = (length_reg == 0) ? 1 : (length_reg > 262144) ? 262144 : length_reg;
      return (p + 1 >= span) ? 0 : p + 1;
   endfunction

   // divide by 2^15 with ties upward, then clip to 16 bits
   function longint round_q15(longint v);
      longint q;
      q = (v + 16384) >>> 15;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q;
   endfunction

   function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_MIX:      mix_reg = val[15:0];
         CSR_FEEDBACK: fb_reg = val[14:0];
         CSR_LENGTH: begin
            length_reg = val;
            wr_pos     = 0;
            rd_pos     = 0;
         end
         default: ;
      endcase
   endfunction

   // update state for one accepted transaction and queue its result; unused codes queue nothing
   function void take_item(req_type it);
      longint  x;
      longint  stored;
      longint  mixv;
      longint  fbv;
      longint  outv;
      rsp_type want;
      outv = 0;
      case (it.op)
         OP_SAMPLE: begin
            x    = $signed(it.sample_in);
            outv = x;
            if (recording) begin
               loop_mem[wr_pos] = it.sample_in;
               wr_pos = next_pos(wr_pos);
            end
            if (playing) begin
               mixv   = (mix_reg > Q_ONE) ? Q_ONE : mix_reg;
               fbv    = (fb_reg > FEEDBACK_MAX) ? FEEDBACK_MAX : fb_reg;
               stored = loop_mem.exists(rd_pos) ? $signed(loop_mem[rd_pos]) : 0;
               outv   = round_q15(x * (Q_ONE - mixv) + stored * mixv);
               loop_mem[wr_pos] = sample_type'(round_q15(outv * fbv));
               wr_pos = next_pos(wr_pos);
               rd_pos = next_pos(rd_pos);
            end
         end
         OP_REC_START: begin
            recording = 1'b1;
            playing   = 1'b0;
            wr_pos    = 0;
         end
         OP_REC_STOP: begin
            recording = 1'b0;
            playing   = 1'b1;
            rd_pos    = 0;
         end
         OP_PLAY_START: playing = 1'b1;
         OP_PLAY_STOP:  playing = 1'b0;
         OP_CLEAR: begin
            loop_mem.delete();
            recording = 1'b0;
            playing   = 1'b0;
            wr_pos    = 0;
            rd_pos    = 0;
         end
         default: return;
      endcase
      want.sample_out   = sample_type'(outv);
      want.is_recording = recording;
      want.is_playing   = playing;
      expected_q.push_back(want);
   endfunction

   // compare one result transaction with the oldest expectation
   function void check_output(rsp_type got);
      rsp_type want;
      if (expected_q.size() == 0) begin
         errors++;
         $display("%0t: unexpected result: sample_out %0d is_recording %0b is_playing %0b",
                  $time, got.sample_out, got.is_recording, got.is_playing);
         return;
      end
      want = expected_q.pop_front();
      if (got.sample_out !== want.sample_out) begin
         errors++;
         $display("%0t: sample_out expected %0d actual %0d",
                  $time, want.sample_out, got.sample_out);
      end
      if (got.is_recording !== want.is_recording) begin
         errors++;
         $display("%0t: is_recording expected %0b actual %0b",
                  $time, want.is_recording, got.is_recording);
      end
      if (got.is_playing !== want.is_playing) begin
         errors++;
         $display("%0t: is_playing expected %0b actual %0b",
                  $time, want.is_playing, got.is_playing);
      end
   endfunction
endclass

module tb_audio_looper_overdub;

   // op codes the block ignores
   localparam logic [2:0] OP_UNUSED_6 = 3'd6;
   localparam logic [2:0] OP_UNUSED_7 = 3'd7;
   localparam int SEGMENTS = 12;
   localparam int SEGMENT_ITEMS = 120;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_MIX;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int send_idle_pct = 34;
   int stall_pct = 70;

   // register settings per random segment, extremes included; segments 4 and 9 draw random ones instead
   int unsigned mix_table [SEGMENTS] = '{16384, 0, 32768, 65535, 0, 40000,
                                         12000, 1, 32767, 0, 20000, 16384};
   int unsigned fb_table [SEGMENTS] = '{16384, 0, 29491, 32767, 0, 20000,
                                        29491, 1, 29490, 0, 8000, 16384};
   int unsigned len_table [SEGMENTS] = '{8, 1, 5, 0, 0, 262144,
                                         524287, 2, 13, 0, 31, 176400};

   loop_predictor model = new();

   audio_looper_overdub u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // receiver back pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         model.check_output(rsp_data);
      end
   end

   // one input transaction, after a random idle gap
   task automatic send_item(input logic [2:0] code, input int value);
      int gap;
      req_type it;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
      it.op        = op_type'(code);
      it.sample_in = sample_type'(value);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = it;
      do @(posedge clock); while (req_stall);
      model.take_item(it);
   endtask

   task automatic write_csr(input csr_index_type idx, input int unsigned val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      model.write_reg(idx, csr_data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // drop valid, wait for every result, then let trailing work finish
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (model.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic int rand_sample();
      case ($urandom_range(9))
         0: return 32767;
         1: return -32768;
         2: return int'($urandom_range(64)) - 32;
         default: return int'($urandom_range(65535)) - 32768;
      endcase
   endfunction

   // weighted op choice, clear left out because it walks the whole store
   function automatic logic [2:0] rand_op();
      int pick;
      pick = $urandom_range(99);
      if (pick < 76) return OP_SAMPLE;
      if (pick < 81) return OP_REC_START;
      if (pick < 87) return OP_REC_STOP;
      if (pick < 92) return OP_PLAY_START;
      if (pick < 97) return OP_PLAY_STOP;
      return ($urandom_range(1) == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
   endfunction

   initial begin
      int seg;
      int count;
      logic [2:0] code;
      int unsigned mix_v;
      int unsigned fb_v;
      int unsigned len_v;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: short loop so the recording wraps
      write_csr(CSR_LENGTH, 3);
      send_item(OP_SAMPLE, 32767);
      send_item(OP_SAMPLE, -32768);
      send_item(OP_UNUSED_6, 1234);
      send_item(OP_UNUSED_7, -1);
      send_item(OP_REC_START, 0);
      send_item(OP_SAMPLE, 32767);
      send_item(OP_SAMPLE, -32768);
      send_item(OP_SAMPLE, -1);
      send_item(OP_SAMPLE, 21845);
      // recording and playing together
      send_item(OP_PLAY_START, 0);
      send_item(OP_SAMPLE, -21846);
      send_item(OP_SAMPLE, 0);
      send_item(OP_REC_STOP, 777);
      send_item(OP_SAMPLE, 12345);
      send_item(OP_SAMPLE, -32768);
      send_item(OP_SAMPLE, 32767);
      send_item(OP_PLAY_STOP, 0);
      send_item(OP_SAMPLE, 100);
      send_item(OP_PLAY_START, 0);
      send_item(OP_SAMPLE, 1);
      send_item(OP_CLEAR, 0);
      send_item(OP_PLAY_START, 0);
      send_item(OP_SAMPLE, -5);
      settle();

      // random segments, each under its own register setting
      for (seg = 0; seg < SEGMENTS; seg++) begin
         if (seg < 4) begin
            send_idle_pct = 34;
            stall_pct     = 70;
         end else if (seg < 8) begin
            send_idle_pct = 70;
            stall_pct     = 34;
         end else begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         mix_v = mix_table[seg];
         fb_v  = fb_table[seg];
         len_v = len_table[seg];
         if (seg % 5 == 4) begin
            mix_v = $urandom_range(65535);
            fb_v  = $urandom_range(32767);
            len_v = $urandom_range(1, 40);
         end
         write_csr(CSR_MIX, mix_v);
         write_csr(CSR_FEEDBACK, fb_v);
         write_csr(CSR_LENGTH, len_v);
         count = 0;
         while (count < SEGMENT_ITEMS) begin
            code = (seg == 6 && count == SEGMENT_ITEMS / 2) ? OP_CLEAR : rand_op();
            send_item(code, rand_sample());
            if (code != OP_UNUSED_6 && code != OP_UNUSED_7) count++;
         end
         settle();
      end

      repeat (20) @(posedge clock);
      if (model.pending() != 0)
         $display("%0t: %0d expected results never arrived", $time, model.pending());
      if (model.errors == 0 && model.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // run limit, covers the clearing passes several times over
   initial begin
      #40_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
